### hdl/aabbq_pkg.sv
// ----------------------------------------------------------------------------
// aabbq_pkg
// Shared constants and types for the bounding box collision table: coordinate
// and entry formats, result bundle, register indexes and operation codes.
// ----------------------------------------------------------------------------
package aabbq_pkg;

  localparam int MAX_BLOCKS = 64;
  localparam int COORD_W    = 16;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int SLOT_W     = 6;
  localparam int BCOUNT_W   = 7;
  localparam int SNAP_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [SNAP_W-1:0] SNAP_RESET = SNAP_W'(20);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SNAP_WINDOW = CFG_IDX_W'(1);

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t left;
    coord_t top;
    coord_t right;
    coord_t bottom;
  } rect_t;

  typedef struct packed {
    rect_t rect;
    logic  passable;
  } entry_t;

  typedef struct packed {
    logic   start;
    logic   entry_vld;
  } scan_ctl_t;

  typedef struct packed {
    logic   solid_hit;
    rect_t  solid;
    logic   blocking_hit;
    rect_t  blocking;
    logic   ground_found;
    coord_t ground_level;
  } result_t;

endpackage

### hdl/aabbq_ifs.sv
// ----------------------------------------------------------------------------
// aabbq channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface aabbq_in_if;
  import aabbq_pkg::*;

  logic                valid;
  logic                ready;
  logic                operation;
  logic [SLOT_W-1:0]   entry_index;
  coord_t              rect_left;
  coord_t              rect_top;
  coord_t              rect_right;
  coord_t              rect_bottom;
  logic                passable_flag;

  modport source (
    output valid, operation, entry_index, rect_left, rect_top, rect_right,
           rect_bottom, passable_flag,
    input  ready
  );

  modport sink (
    input  valid, operation, entry_index, rect_left, rect_top, rect_right,
           rect_bottom, passable_flag,
    output ready
  );
endinterface

interface aabbq_out_if;
  import aabbq_pkg::*;

  logic   valid;
  logic   ready;
  logic   solid_hit;
  coord_t solid_left;
  coord_t solid_top;
  coord_t solid_right;
  coord_t solid_bottom;
  logic   blocking_hit;
  coord_t blocking_left;
  coord_t blocking_top;
  coord_t blocking_right;
  coord_t blocking_bottom;
  logic   ground_found;
  coord_t ground_level;

  modport source (
    output valid, solid_hit, solid_left, solid_top, solid_right, solid_bottom,
           blocking_hit, blocking_left, blocking_top, blocking_right,
           blocking_bottom, ground_found, ground_level,
    input  ready
  );

  modport sink (
    input  valid, solid_hit, solid_left, solid_top, solid_right, solid_bottom,
           blocking_hit, blocking_left, blocking_top, blocking_right,
           blocking_bottom, ground_found, ground_level,
    output ready
  );
endinterface

interface aabbq_cfg_if;
  import aabbq_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hdl/aabbq_store.sv
// ----------------------------------------------------------------------------
// aabbq_store
// Block table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module aabbq_store (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [aabbq_pkg::IDX_W-1:0] wr_addr,
  input  aabbq_pkg::entry_t        wr_entry,
  input  logic                     rd_en,
  input  logic [aabbq_pkg::IDX_W-1:0] rd_addr,
  output aabbq_pkg::entry_t        rd_entry
);
  import aabbq_pkg::*;

  entry_t mem [MAX_BLOCKS];
  entry_t rd_entry_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry_r <= mem[rd_addr];
    end
  end

  assign rd_entry = rd_entry_r;

endmodule

### hdl/aabbq_scan.sv
// ----------------------------------------------------------------------------
// aabbq_scan
// Per-entry compare and accumulate: first overlap, first non-passable overlap
// and lowest ground top within the snap window.
// ----------------------------------------------------------------------------
module aabbq_scan (
  input  logic                        clk,
  input  aabbq_pkg::scan_ctl_t        ctl,
  input  aabbq_pkg::rect_t            query,
  input  logic [aabbq_pkg::SNAP_W-1:0] snap_window,
  input  aabbq_pkg::entry_t           entry,
  output aabbq_pkg::result_t          result
);
  import aabbq_pkg::*;

  rect_t   query_r;
  result_t acc_r;

  coord_t ql, qt, qr, qb;
  coord_t el, et, er, eb;
  logic signed [COORD_W:0] qb_ext;
  logic signed [COORD_W:0] gnd_lim;
  logic horiz, hit, ground_ok;

  always_comb begin
    ql = query_r.left;
    qt = query_r.top;
    qr = query_r.right;
    qb = query_r.bottom;
    el = entry.rect.left;
    et = entry.rect.top;
    er = entry.rect.right;
    eb = entry.rect.bottom;
    qb_ext  = (COORD_W+1)'(qb);
    gnd_lim = (COORD_W+1)'(et) + (COORD_W+1)'({1'b0, snap_window});
    horiz     = (qr > el) && (ql < er);
    hit       = horiz && (qb > et) && (qt < eb);
    ground_ok = horiz && (qb >= et) && (qb_ext <= gnd_lim);
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      query_r <= query;
      acc_r   <= '0;
    end else if (ctl.entry_vld) begin
      if (hit && !acc_r.solid_hit) begin
        acc_r.solid_hit <= 1'b1;
        acc_r.solid     <= entry.rect;
      end
      if (hit && !acc_r.blocking_hit && !entry.passable) begin
        acc_r.blocking_hit <= 1'b1;
        acc_r.blocking     <= entry.rect;
      end
      if (ground_ok && (!acc_r.ground_found || (et < acc_r.ground_level))) begin
        acc_r.ground_found <= 1'b1;
        acc_r.ground_level <= et;
      end
    end
  end

  assign result = acc_r;

endmodule

### hdl/aabb_collision_table_query_top.sv
// ----------------------------------------------------------------------------
// aabb_collision_table_query_top
// Rectangle collision table: write items store blocks, query items scan the
// table and return the first overlap, first blocking overlap and ground level.
// ----------------------------------------------------------------------------
//  channel | dir | transaction
//  in_ch   | in  | write item (store one block) or query item
//  out_ch  | out | one result per query, none per write
//  cfg_ch  | in  | register write: block_count, ground_snap_window
//
//  a write item is stored when it is accepted; a query scans n table entries,
//  n being block_count limited to 64, one table entry per cycle through the
//  single read port of the block memory
//  reset clears control and registers; table contents stay undefined
//  a finished result waits in the output register while the next item enters;
//  a query that finishes while that result still waits holds the input
// ----------------------------------------------------------------------------
module aabb_collision_table_query_top (
  input logic        clk,
  input logic        rst_n,
  aabbq_in_if.sink   in_ch,
  aabbq_out_if.source out_ch,
  aabbq_cfg_if.sink  cfg_ch
);
  import aabbq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] rd_cnt_r, rd_cnt_nxt;
  logic [CNT_W-1:0] num_r, num_nxt;
  logic rd_vld_r;
  logic [BCOUNT_W-1:0] block_count_r;
  logic [SNAP_W-1:0]   snap_window_r;
  logic    out_valid_r;
  result_t out_res_r;

  logic      in_acc, wr_en, rd_en, load_out;
  entry_t    wr_entry, rd_entry;
  rect_t     in_rect;
  scan_ctl_t scan_ctl;
  result_t   scan_res;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_rect     = '{left: in_ch.rect_left, top: in_ch.rect_top,
                         right: in_ch.rect_right, bottom: in_ch.rect_bottom};
  assign wr_entry    = '{rect: in_rect, passable: in_ch.passable_flag};
  assign wr_en       = in_acc && (in_ch.operation == OP_WRITE)
                       && (32'(in_ch.entry_index) < MAX_BLOCKS);
  assign rd_en       = (state_r == ST_SCAN) && (rd_cnt_r < num_r);
  assign load_out    = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  assign scan_ctl.start     = in_acc && (in_ch.operation == OP_QUERY);
  assign scan_ctl.entry_vld = rd_vld_r;

  always_comb begin
    state_nxt  = state_r;
    rd_cnt_nxt = rd_cnt_r;
    num_nxt    = num_r;
    case (state_r)
      ST_IDLE: begin
        if (scan_ctl.start) begin
          rd_cnt_nxt = '0;
          num_nxt    = (32'(block_count_r) > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS)
                                                         : CNT_W'(block_count_r);
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          rd_cnt_nxt = rd_cnt_r + CNT_W'(1);
        end else if (!rd_vld_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rd_cnt_r <= '0;
      num_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_cnt_r <= rd_cnt_nxt;
      num_r    <= num_nxt;
      rd_vld_r <= rd_en;
    end
  end

  // register writes
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_count_r <= '0;
      snap_window_r <= SNAP_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        CFG_BLOCK_COUNT: block_count_r <= cfg_ch.data[BCOUNT_W-1:0];
        CFG_SNAP_WINDOW: snap_window_r <= cfg_ch.data[SNAP_W-1:0];
        default: ;
      endcase
    end
  end

  aabbq_store u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (IDX_W'(in_ch.entry_index)),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .rd_addr  (rd_cnt_r[IDX_W-1:0]),
    .rd_entry (rd_entry)
  );

  aabbq_scan u_scan (
    .clk         (clk),
    .ctl         (scan_ctl),
    .query       (in_rect),
    .snap_window (snap_window_r),
    .entry       (rd_entry),
    .result      (scan_res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_res_r <= scan_res;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.solid_hit       = out_res_r.solid_hit;
  assign out_ch.solid_left      = out_res_r.solid.left;
  assign out_ch.solid_top       = out_res_r.solid.top;
  assign out_ch.solid_right     = out_res_r.solid.right;
  assign out_ch.solid_bottom    = out_res_r.solid.bottom;
  assign out_ch.blocking_hit    = out_res_r.blocking_hit;
  assign out_ch.blocking_left   = out_res_r.blocking.left;
  assign out_ch.blocking_top    = out_res_r.blocking.top;
  assign out_ch.blocking_right  = out_res_r.blocking.right;
  assign out_ch.blocking_bottom = out_res_r.blocking.bottom;
  assign out_ch.ground_found    = out_res_r.ground_found;
  assign out_ch.ground_level    = out_res_r.ground_level;

endmodule

### test/aabb_collision_table_query_top_tb.sv
// ----------------------------------------------------------------------------
// aabb_collision_table_query_top_tb
// Self-checking bench for the rectangle collision table. Write and query
// transactions go in through the input channel, and every query result is
// checked against a predicted copy of the table and registers. A short
// directed set covers the edge comparisons, the ground window and coordinate
// extremes. Random phases then vary block_count and the snap window, with
// bursty input traffic and receiver back-pressure.
// ----------------------------------------------------------------------------
module aabb_collision_table_query_top_tb;
  import aabbq_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);
  localparam int IDLE_PAUSE  = MAX_BLOCKS + 16;
  localparam int CYCLE_LIMIT = 500000;
  localparam int NUM_PHASES  = 9;

  class contact_scoreboard;
    entry_t               blocks [MAX_BLOCKS];
    logic [BCOUNT_W-1:0]  count_reg;
    logic [SNAP_W-1:0]    snap_reg;
    result_t              pending_results [$];
    int                   failures;

    function new();
      count_reg = '0;
      snap_reg  = SNAP_RESET;
      failures  = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_BLOCK_COUNT)
        count_reg = data[BCOUNT_W-1:0];
      else if (idx == CFG_SNAP_WINDOW)
        snap_reg = data[SNAP_W-1:0];
    endfunction

    function int searched();
      return (count_reg > MAX_BLOCKS) ? MAX_BLOCKS : int'(count_reg);
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    function void note_item(logic op, logic [SLOT_W-1:0] slot, rect_t r, logic pass);
      result_t res;
      longint  ql, qt, qr, qb, el, et, er, eb, gl;
      bit      overlap, ground;
      int      n;
      if (op == OP_WRITE) begin
        blocks[slot].rect     = r;
        blocks[slot].passable = pass;
        return;
      end
      res    = '0;
      ground = 1'b0;
      gl     = longint'(0);
      ql = longint'(r.left);
      qt = longint'(r.top);
      qr = longint'(r.right);
      qb = longint'(r.bottom);
      n  = searched();
      for (int i = 0; i < n; i++) begin
        el = longint'(blocks[i].rect.left);
        et = longint'(blocks[i].rect.top);
        er = longint'(blocks[i].rect.right);
        eb = longint'(blocks[i].rect.bottom);
        overlap = (qr > el) && (ql < er) && (qb > et) && (qt < eb);
        if (overlap && !res.solid_hit) begin
          res.solid_hit = 1'b1;
          res.solid     = blocks[i].rect;
        end
        if (overlap && !res.blocking_hit && !blocks[i].passable) begin
          res.blocking_hit = 1'b1;
          res.blocking     = blocks[i].rect;
        end
        if (qr > el && ql < er && qb >= et && qb <= et + longint'(snap_reg)) begin
          if (!ground || et < gl) begin
            gl     = et;
            ground = 1'b1;
          end
        end
      end
      res.ground_found = ground;
      res.ground_level = coord_t'(gl);
      pending_results.push_back(res);
    endfunction

    function void compare_field(string name, logic [COORD_W-1:0] e, logic [COORD_W-1:0] g);
      if (g !== e) begin
        failures++;
        if (failures <= 10)
          $display("mismatch on %s: expected %0d, got %0d", name, $signed(e), $signed(g));
      end
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("result with no query outstanding: %h", got);
        return;
      end
      exp = pending_results.pop_front();
      compare_field("solid_hit", COORD_W'(exp.solid_hit), COORD_W'(got.solid_hit));
      compare_field("solid_left",      exp.solid.left,      got.solid.left);
      compare_field("solid_top",       exp.solid.top,       got.solid.top);
      compare_field("solid_right",     exp.solid.right,     got.solid.right);
      compare_field("solid_bottom",    exp.solid.bottom,    got.solid.bottom);
      compare_field("blocking_hit", COORD_W'(exp.blocking_hit), COORD_W'(got.blocking_hit));
      compare_field("blocking_left",   exp.blocking.left,   got.blocking.left);
      compare_field("blocking_top",    exp.blocking.top,    got.blocking.top);
      compare_field("blocking_right",  exp.blocking.right,  got.blocking.right);
      compare_field("blocking_bottom", exp.blocking.bottom, got.blocking.bottom);
      compare_field("ground_found", COORD_W'(exp.ground_found), COORD_W'(got.ground_found));
      compare_field("ground_level",    exp.ground_level,    got.ground_level);
    endfunction
  endclass

  logic clk;
  logic rst_n;

  aabbq_in_if  in_ch ();
  aabbq_out_if out_ch ();
  aabbq_cfg_if cfg_ch ();

  aabb_collision_table_query_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  contact_scoreboard contacts = new();

  bit  slot_written [MAX_BLOCKS];
  int  filled_prefix = 0;
  int  burst_left = 0;
  int  cycle_count = 0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver back-pressure, cycling through four ready patterns
  initial begin : result_receiver
    int  rcv_cycle;
    int  hold;
    logic level;
    rcv_cycle = 0;
    hold = 0;
    level = 1'b1;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rcv_cycle++;
      case ((rcv_cycle / 300) % 4)
        0: out_ch.ready = 1'b1;
        1: out_ch.ready = ($urandom_range(0, 9) < 7);
        2: begin
          if (hold == 0) begin
            hold  = $urandom_range(1, 16);
            level = ~level;
          end
          hold--;
          out_ch.ready = level;
        end
        default: out_ch.ready = rcv_cycle[0];
      endcase
    end
  end

  always @(posedge clk) begin : result_monitor
    result_t got;
    got.solid_hit       = out_ch.solid_hit;
    got.solid.left      = out_ch.solid_left;
    got.solid.top       = out_ch.solid_top;
    got.solid.right     = out_ch.solid_right;
    got.solid.bottom    = out_ch.solid_bottom;
    got.blocking_hit    = out_ch.blocking_hit;
    got.blocking.left   = out_ch.blocking_left;
    got.blocking.top    = out_ch.blocking_top;
    got.blocking.right  = out_ch.blocking_right;
    got.blocking.bottom = out_ch.blocking_bottom;
    got.ground_found    = out_ch.ground_found;
    got.ground_level    = out_ch.ground_level;
    if (rst_n && out_ch.valid && out_ch.ready)
      contacts.check_result(got);
  end

  function automatic rect_t mk_rect(int l, int t, int r, int b);
    rect_t rr;
    rr.left   = coord_t'(l);
    rr.top    = coord_t'(t);
    rr.right  = coord_t'(r);
    rr.bottom = coord_t'(b);
    return rr;
  endfunction

  function automatic coord_t clamp_coord(int v);
    if (v > 32767)
      return coord_t'(32767);
    if (v < -32768)
      return coord_t'(-32768);
    return coord_t'(v);
  endfunction

  function automatic coord_t extreme_coord();
    case ($urandom_range(0, 3))
      0: return coord_t'(-32768);
      1: return coord_t'(-32767);
      2: return coord_t'(32766);
      default: return coord_t'(32767);
    endcase
  endfunction

  function automatic rect_t random_rect();
    rect_t r;
    int    sel;
    int    l, t;
    sel = $urandom_range(0, 99);
    if (sel < 10) begin
      r = rect_t'({$urandom, $urandom});
    end else if (sel < 15) begin
      r.left   = extreme_coord();
      r.top    = extreme_coord();
      r.right  = extreme_coord();
      r.bottom = extreme_coord();
    end else begin
      l = int'($urandom_range(0, 256)) - 128;
      t = int'($urandom_range(0, 256)) - 128;
      if (sel < 20)
        r = mk_rect(l, t, l - int'($urandom_range(0, 20)), t - int'($urandom_range(0, 20)));
      else
        r = mk_rect(l, t, l + int'($urandom_range(0, 48)), t + int'($urandom_range(0, 48)));
    end
    return r;
  endfunction

  // query whose bottom lands near the top of a stored block
  function automatic rect_t ground_probe(rect_t blk, int snap);
    rect_t q;
    int    b;
    b = int'(blk.top) + int'($urandom_range(0, snap + 3)) - 1;
    q.left   = clamp_coord(int'(blk.left) - int'($urandom_range(0, 8)) + 4);
    q.right  = clamp_coord(int'(blk.right) + int'($urandom_range(0, 8)) - 4);
    q.bottom = clamp_coord(b);
    q.top    = clamp_coord(b - int'($urandom_range(1, 40)));
    return q;
  endfunction

  task automatic send_item(logic op, logic [SLOT_W-1:0] slot, rect_t r, logic pass);
    @(negedge clk);
    in_ch.valid         = 1'b1;
    in_ch.operation     = op;
    in_ch.entry_index   = slot;
    in_ch.rect_left     = r.left;
    in_ch.rect_top      = r.top;
    in_ch.rect_right    = r.right;
    in_ch.rect_bottom   = r.bottom;
    in_ch.passable_flag = pass;
    do @(posedge clk); while (!in_ch.ready);
    contacts.note_item(op, slot, r, pass);
    if (op == OP_WRITE) begin
      slot_written[slot] = 1'b1;
      while (filled_prefix < MAX_BLOCKS && slot_written[filled_prefix])
        filled_prefix++;
    end
  endtask

  task automatic idle_gap(int cycles);
    for (int i = 0; i < cycles; i++) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    do @(posedge clk); while (!cfg_ch.ready);
    contacts.set_register(idx, data);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // drain all results, then give a trailing write time to finish
  task automatic settle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (contacts.outstanding() > 0)
      @(posedge clk);
    repeat (IDLE_PAUSE) @(posedge clk);
  endtask

  task automatic start_phase(logic [CFG_DATA_W-1:0] count_data, logic [CFG_DATA_W-1:0] snap_data);
    int eff;
    settle();
    eff = int'(count_data[BCOUNT_W-1:0]);
    if (eff > MAX_BLOCKS)
      eff = MAX_BLOCKS;
    if (eff > filled_prefix)
      count_data = CFG_DATA_W'(filled_prefix);
    write_register(CFG_BLOCK_COUNT, count_data);
    write_register(CFG_SNAP_WINDOW, snap_data);
    write_register($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, CFG_DATA_W'($urandom));
  endtask

  task automatic random_phase(int items, int write_pct);
    rect_t r;
    logic  op;
    logic [SLOT_W-1:0] slot;
    int    n;
    for (int k = 0; k < items; k++) begin
      if (burst_left == 0) begin
        idle_gap($urandom_range(0, 8));
        burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
      end
      burst_left--;
      n = contacts.searched();
      if (int'($urandom_range(0, 99)) < write_pct) begin
        op   = OP_WRITE;
        slot = (filled_prefix < MAX_BLOCKS) ? SLOT_W'(filled_prefix) : SLOT_W'($urandom);
        r    = random_rect();
      end else begin
        op   = OP_QUERY;
        slot = SLOT_W'($urandom);
        if (n > 0 && $urandom_range(0, 99) < 35)
          r = ground_probe(contacts.blocks[$urandom_range(0, n - 1)].rect,
                           int'(contacts.snap_reg));
        else
          r = random_rect();
      end
      send_item(op, slot, r, 1'($urandom));
    end
  endtask

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] phase_count [NUM_PHASES];
    logic [CFG_DATA_W-1:0] phase_snap  [NUM_PHASES];
    int                    phase_items [NUM_PHASES];
    phase_count = '{8'd8, 8'd64, 8'hFF, 8'h80, 8'd1, 8'($urandom), 8'($urandom),
                    8'($urandom), 8'd64};
    phase_snap  = '{8'd20, 8'd255, 8'd0, 8'($urandom), 8'd20, 8'($urandom),
                    8'($urandom), 8'd255, 8'($urandom)};
    phase_items = '{100, 100, 90, 40, 60, 65, 65, 65, 65};

    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.operation     = OP_WRITE;
    in_ch.entry_index   = '0;
    in_ch.rect_left     = '0;
    in_ch.rect_top      = '0;
    in_ch.rect_right    = '0;
    in_ch.rect_bottom   = '0;
    in_ch.passable_flag = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = CFG_BLOCK_COUNT;
    cfg_ch.data         = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty search after reset
    send_item(OP_QUERY, '0, mk_rect(-10, -10, 10, 10), 1'b0);

    send_item(OP_WRITE, 6'd0, mk_rect(0, 100, 50, 110), 1'b1);
    send_item(OP_WRITE, 6'd1, mk_rect(40, 90, 80, 130), 1'b0);
    send_item(OP_WRITE, 6'd2, mk_rect(-32768, -32768, -32700, -32700), 1'b0);
    send_item(OP_WRITE, 6'd3, mk_rect(32700, 32700, 32767, 32767), 1'b1);
    send_item(OP_WRITE, 6'd4, mk_rect(200, 50, 300, 60), 1'b0);
    send_item(OP_WRITE, 6'd5, mk_rect(200, 40, 300, 45), 1'b0);
    send_item(OP_WRITE, 6'd6, mk_rect(-100, -100, -50, -50), 1'b1);
    send_item(OP_WRITE, 6'd7, mk_rect(-32768, 32767, 32767, -32768), 1'b0);
    settle();
    write_register(CFG_BLOCK_COUNT, 8'd8);

    // passable block first, blocking one second
    send_item(OP_QUERY, 6'd63, mk_rect(10, 95, 45, 105), 1'b1);
    // touching edges: the first query also overlaps block 1, the second only touches
    send_item(OP_QUERY, '0, mk_rect(50, 100, 60, 110), 1'b0);
    send_item(OP_QUERY, '0, mk_rect(80, 130, 90, 140), 1'b0);
    // ground at the far edge of the window, just past it, and competing tops
    send_item(OP_QUERY, '0, mk_rect(210, 0, 220, 70), 1'b0);
    send_item(OP_QUERY, '0, mk_rect(210, 0, 220, 71), 1'b0);
    send_item(OP_QUERY, '0, mk_rect(210, 0, 220, 60), 1'b0);
    send_item(OP_QUERY, '0, mk_rect(210, 0, 220, 50), 1'b0);
    // coordinate extremes
    send_item(OP_QUERY, '0, mk_rect(-32768, -32768, -32767, -32767), 1'b0);
    send_item(OP_QUERY, '0, mk_rect(32766, 32766, 32767, 32767), 1'b0);
    send_item(OP_QUERY, '0, mk_rect(-32768, -32768, 32767, 32767), 1'b0);
    // only a passable block overlaps
    send_item(OP_QUERY, '0, mk_rect(-90, -90, -60, -60), 1'b0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      start_phase(phase_count[p], phase_snap[p]);
      random_phase(phase_items[p], (p == 0) ? 60 : 25);
    end

    settle();
    if (contacts.failures == 0 && contacts.outstanding() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
